@@ rtl/core/mtfk_pkg.sv @@
`timescale 1ns / 1ps
package mtfk_pkg;

   localparam int CACHE_ENTRIES = 64;
   localparam int NUM_W = 24;
   localparam int GEN_W = 16;
   localparam int POS_W = 6;

   typedef struct packed {
      logic [NUM_W-1:0] object_number;
      logic [GEN_W-1:0] generation;
      logic             print_mode;
      logic             special;
      logic             valid;
   } entry_type;

   typedef struct packed {
      logic [NUM_W-1:0] object_number;
      logic [GEN_W-1:0] generation;
      logic             print_mode;
      logic             is_special_kind;
      logic             create_ok;
   } key_type;

   // per-cycle control shared by every cell
   typedef struct packed {
      logic capture;
      logic update;
   } cell_ctl_type;

   // data rippling down the row during the update cycle
   typedef struct packed {
      logic             seen;
      entry_type        found;
      logic [POS_W-1:0] pos;
   } chain_type;

endpackage

@@ rtl/core/move_to_front_key_cache.sv @@
`timescale 1ns / 1ps
// Move-to-front key cache: fully associative, kept in most-recently-used order.
// Lookup channel: present req_* fields with start high; the item is taken at a
// clock edge where start is high and busy is low. busy is then high for one
// cycle while the row of cells reorders.
// Result channel: rsp_strobe is high for exactly one cycle, once the row of cells
// has reordered for the taken lookup, with rsp_hit, rsp_hit_position and the evicted
// entry fields. The receiver cannot stall; each result must be sampled then.
// Each lookup first registers the compare of every cell against the key, then
// ripples the first-match search down the row of cells and shifts them. A new
// lookup may be taken in the same cycle that the previous result is shown.
// Reset (synchronous, active high) empties the cache at once: all entries
// invalid, no clearing pass, no result pending.
module move_to_front_key_cache (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [mtfk_pkg::NUM_W-1:0] req_object_number,
   input  logic [mtfk_pkg::GEN_W-1:0] req_generation,
   input  logic                       req_print_mode,
   input  logic                       req_is_special_kind,
   input  logic                       req_create_ok,
   output logic                       rsp_strobe,
   output logic                       rsp_hit,
   output logic [mtfk_pkg::POS_W-1:0] rsp_hit_position,
   output logic                       rsp_evicted,
   output logic [mtfk_pkg::NUM_W-1:0] rsp_evicted_object_number,
   output logic [mtfk_pkg::GEN_W-1:0] rsp_evicted_generation,
   output logic                       rsp_evicted_print_mode
);

   localparam int N = mtfk_pkg::CACHE_ENTRIES;

   logic                       busy_ff;
   mtfk_pkg::key_type          key_in;
   mtfk_pkg::key_type          key_ff;
   mtfk_pkg::cell_ctl_type     ctl;
   mtfk_pkg::entry_type        head_entry;
   mtfk_pkg::entry_type        new_entry;
   mtfk_pkg::entry_type        entries [N];
   mtfk_pkg::chain_type        chain [N+1];

   logic                       rsp_strobe_ff;
   logic                       rsp_hit_ff;
   logic [mtfk_pkg::POS_W-1:0] rsp_pos_ff;
   logic                       rsp_evicted_ff;
   mtfk_pkg::entry_type        rsp_evict_entry_ff;
   logic                       hit;
   logic                       evict;

   assign key_in.object_number   = req_object_number;
   assign key_in.generation      = req_generation;
   assign key_in.print_mode      = req_print_mode;
   assign key_in.is_special_kind = req_is_special_kind;
   assign key_in.create_ok       = req_create_ok;

   assign ctl.capture = start && !busy_ff;
   assign ctl.update  = busy_ff;
   assign busy        = busy_ff;

   assign chain[0] = '0;

   assign new_entry.object_number = key_ff.object_number;
   assign new_entry.generation    = key_ff.generation;
   assign new_entry.print_mode    = key_ff.print_mode;
   assign new_entry.special       = key_ff.is_special_kind;
   assign new_entry.valid         = key_ff.create_ok;

   assign hit        = chain[N].seen;
   assign head_entry = hit ? chain[N].found : new_entry;
   assign evict      = !hit && entries[N-1].valid;

   for (genvar i = 0; i < N; i++) begin : g_cell
      mtfk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key_in),
         .cell_pos   (mtfk_pkg::POS_W'(i)),
         .prev_entry ((i == 0) ? head_entry : entries[(i == 0) ? 0 : i-1]),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .entry      (entries[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= ctl.capture;
         rsp_strobe_ff <= ctl.update;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         key_ff <= key_in;
      end
      if (ctl.update) begin
         rsp_hit_ff         <= hit;
         rsp_pos_ff         <= hit ? chain[N].pos : '0;
         rsp_evicted_ff     <= evict;
         rsp_evict_entry_ff <= evict ? entries[N-1] : '0;
      end
   end

   assign rsp_strobe                = rsp_strobe_ff;
   assign rsp_hit                   = rsp_hit_ff;
   assign rsp_hit_position          = rsp_pos_ff;
   assign rsp_evicted               = rsp_evicted_ff;
   assign rsp_evicted_object_number = rsp_evict_entry_ff.object_number;
   assign rsp_evicted_generation    = rsp_evict_entry_ff.generation;
   assign rsp_evicted_print_mode    = rsp_evict_entry_ff.print_mode;

endmodule

@@ rtl/core/mtfk_cell.sv @@
`timescale 1ns / 1ps
module mtfk_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  mtfk_pkg::cell_ctl_type        ctl,
   input  mtfk_pkg::key_type             key,
   input  logic [mtfk_pkg::POS_W-1:0]    cell_pos,
   input  mtfk_pkg::entry_type           prev_entry,
   input  mtfk_pkg::chain_type           chain_in,
   output mtfk_pkg::chain_type           chain_out,
   output mtfk_pkg::entry_type           entry
);

   mtfk_pkg::entry_type entry_ff;
   logic                match_ff;
   logic                match_in;
   logic                first;

   assign match_in = entry_ff.valid
                     && (entry_ff.object_number == key.object_number)
                     && (entry_ff.generation == key.generation)
                     && (!entry_ff.special || (entry_ff.print_mode == key.print_mode));

   // first match in order: no match in any earlier cell
   assign first = match_ff && !chain_in.seen;

   always_comb begin
      chain_out.seen  = chain_in.seen | match_ff;
      chain_out.found = first ? entry_ff : chain_in.found;
      chain_out.pos   = first ? cell_pos : chain_in.pos;
   end

   assign entry = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         match_ff <= 1'b0;
      end else begin
         if (ctl.capture) begin
            match_ff <= match_in;
         end
         // cells up to and including the hit (all cells on a miss) take the neighbor's entry
         if (ctl.update && !chain_in.seen) begin
            entry_ff <= prev_entry;
         end
      end
   end

endmodule

@@ rtl/core/mtfk_checker.sv @@
`timescale 1ns / 1ps
module mtfk_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic                       rsp_hit,
   input logic [mtfk_pkg::POS_W-1:0] rsp_hit_position,
   input logic                       rsp_evicted
);

   // every taken item is followed by busy and then by its result strobe
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 rsp_strobe)
      else $error("result strobe missing after taken item");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a lookup in progress");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> !rsp_evicted)
      else $error("eviction reported on a hit");

   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_hit_position == '0))
      else $error("nonzero position on a miss");

endmodule

bind move_to_front_key_cache mtfk_checker u_mtfk_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_hit          (rsp_hit),
   .rsp_hit_position (rsp_hit_position),
   .rsp_evicted      (rsp_evicted)
);

@@ bench/tb_move_to_front_key_cache.sv @@
`timescale 1ns / 1ps
module tb_move_to_front_key_cache;
   import mtfk_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] position;
      logic             evicted;
      logic [NUM_W-1:0] object_number;
      logic [GEN_W-1:0] generation;
      logic             print_mode;
   } lookup_result_type;

   typedef struct {
      key_type key;
      bit      drain_first;
   } lookup_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [NUM_W-1:0] req_object_number = '0;
   logic [GEN_W-1:0] req_generation = '0;
   logic req_print_mode = 1'b0;
   logic req_is_special_kind = 1'b0;
   logic req_create_ok = 1'b0;
   logic rsp_strobe;
   logic rsp_hit;
   logic [POS_W-1:0] rsp_hit_position;
   logic rsp_evicted;
   logic [NUM_W-1:0] rsp_evicted_object_number;
   logic [GEN_W-1:0] rsp_evicted_generation;
   logic rsp_evicted_print_mode;

   entry_type shadow_cache [CACHE_ENTRIES];
   lookup_item_type lookup_queue [$];
   lookup_result_type results_due [$];
   lookup_item_type head_item;
   lookup_result_type got_result;
   lookup_result_type want_result;
   bit item_taken = 1'b0;
   int lookups_taken = 0;
   int total_lookups = 0;
   int mismatches = 0;
   int burst_left = 1;
   int gap_left = 0;
   int pool_sizes [4] = '{5, 40, 64, 110};

   move_to_front_key_cache dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_object_number(req_object_number),
      .req_generation(req_generation),
      .req_print_mode(req_print_mode),
      .req_is_special_kind(req_is_special_kind),
      .req_create_ok(req_create_ok),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_hit_position(rsp_hit_position),
      .rsp_evicted(rsp_evicted),
      .rsp_evicted_object_number(rsp_evicted_object_number),
      .rsp_evicted_generation(rsp_evicted_generation),
      .rsp_evicted_print_mode(rsp_evicted_print_mode)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // first match moves to the front; a miss shifts everything back one slot
   function automatic lookup_result_type apply_lookup(key_type key);
      lookup_result_type res;
      entry_type moved;
      int idx;
      res = '0;
      idx = CACHE_ENTRIES;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (idx == CACHE_ENTRIES && shadow_cache[i].valid
             && shadow_cache[i].object_number == key.object_number
             && shadow_cache[i].generation == key.generation
             && (!shadow_cache[i].special || shadow_cache[i].print_mode == key.print_mode))
            idx = i;
      end
      if (idx < CACHE_ENTRIES) begin
         moved = shadow_cache[idx];
         for (int i = idx; i > 0; i--)
            shadow_cache[i] = shadow_cache[i-1];
         shadow_cache[0] = moved;
         res.hit = 1'b1;
         res.position = idx[POS_W-1:0];
      end else begin
         moved = shadow_cache[CACHE_ENTRIES-1];
         for (int i = CACHE_ENTRIES - 1; i > 0; i--)
            shadow_cache[i] = shadow_cache[i-1];
         shadow_cache[0] = '{key.object_number, key.generation, key.print_mode,
                             key.is_special_kind, key.create_ok};
         if (moved.valid) begin
            res.evicted = 1'b1;
            res.object_number = moved.object_number;
            res.generation = moved.generation;
            res.print_mode = moved.print_mode;
         end
      end
      return res;
   endfunction

   function automatic string result_text(lookup_result_type r);
      return $sformatf("hit=%0b pos=%0d evicted=%0b num=%h gen=%h pm=%0b", r.hit, r.position,
                       r.evicted, r.object_number, r.generation, r.print_mode);
   endfunction

   task automatic note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   task automatic add_lookup(logic [NUM_W-1:0] num, logic [GEN_W-1:0] gen, bit pm, bit spec,
                             bit ok, bit drain);
      lookup_item_type queued;
      queued.key = '{num, gen, pm, spec, ok};
      queued.drain_first = drain;
      lookup_queue.push_back(queued);
   endtask

   // driver: bursts with random gaps, optional wait for all results
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (lookup_queue.size() != 0
                      && (!lookup_queue[0].drain_first || results_due.size() == 0)) begin
            head_item = lookup_queue.pop_front();
            start <= 1'b1;
            req_object_number <= head_item.key.object_number;
            req_generation <= head_item.key.generation;
            req_print_mode <= head_item.key.print_mode;
            req_is_special_kind <= head_item.key.is_special_kind;
            req_create_ok <= head_item.key.create_ok;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check each strobed result, then predict for an item taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         item_taken = 1'b0;
      end else begin
         if (rsp_strobe === 1'b1) begin
            got_result = '{rsp_hit, rsp_hit_position, rsp_evicted, rsp_evicted_object_number,
                           rsp_evicted_generation, rsp_evicted_print_mode};
            if (results_due.size() == 0) begin
               note_mismatch({"result with no lookup outstanding: ", result_text(got_result)});
            end else begin
               want_result = results_due.pop_front();
               if (got_result !== want_result)
                  note_mismatch({"lookup result mismatch: expected ", result_text(want_result),
                                 " got ", result_text(got_result)});
            end
         end
         item_taken = start && (busy === 1'b0);
         if (item_taken) begin
            results_due.push_back(apply_lookup('{req_object_number, req_generation,
                                                 req_print_mode, req_is_special_kind,
                                                 req_create_ok}));
            lookups_taken++;
         end
      end
   end

   initial begin
      logic [NUM_W-1:0] pool_num [];
      logic [GEN_W-1:0] pool_gen [];
      bit pool_spec [];
      int pool_size;
      int pick;

      foreach (shadow_cache[i])
         shadow_cache[i] = '0;

      // directed: key extremes, print mode keying, failed creation, near misses
      add_lookup(24'h000000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
      add_lookup(24'h000000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);
      add_lookup(24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0);
      add_lookup(24'hFFFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0);
      add_lookup(24'hFFFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b0);
      add_lookup(24'h000000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
      add_lookup(24'hABCDE5, 16'h1234, 1'b0, 1'b0, 1'b0, 1'b1);
      add_lookup(24'hABCDE5, 16'h1234, 1'b0, 1'b0, 1'b1, 1'b0);
      add_lookup(24'hABCDE5, 16'h1234, 1'b1, 1'b0, 1'b0, 1'b0);
      add_lookup(24'hABCDE5, 16'h1235, 1'b0, 1'b0, 1'b1, 1'b0);
      add_lookup(24'hABCDE4, 16'h1234, 1'b0, 1'b0, 1'b1, 1'b0);
      add_lookup(24'h555555, 16'hAAAA, 1'b1, 1'b1, 1'b0, 1'b0);
      add_lookup(24'hAAAAAA, 16'h5555, 1'b1, 1'b1, 1'b1, 1'b0);

      // random rounds over key pools of different sizes to reach deep hits and evictions
      foreach (pool_sizes[r]) begin
         pool_size = pool_sizes[r];
         pool_num = new[pool_size];
         pool_gen = new[pool_size];
         pool_spec = new[pool_size];
         foreach (pool_num[i]) begin
            pool_num[i] = NUM_W'($urandom());
            pool_gen[i] = GEN_W'($urandom_range(0, 65535));
            pool_spec[i] = 1'($urandom_range(0, 1));
            // same number, other generation
            if (i > 0 && $urandom_range(0, 3) == 0)
               pool_num[i] = pool_num[i-1];
         end
         for (int n = 0; n < 285; n++) begin
            if ($urandom_range(0, 99) < 80) begin
               pick = $urandom_range(0, pool_size - 1);
               add_lookup(pool_num[pick], pool_gen[pick], 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 7) == 0) ? !pool_spec[pick] : pool_spec[pick],
                          $urandom_range(0, 9) != 0, n == 0 || $urandom_range(0, 99) == 0);
            end else begin
               add_lookup(NUM_W'($urandom()), GEN_W'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 9) != 0, 1'b0);
            end
         end
      end
      total_lookups = lookup_queue.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (lookups_taken != total_lookups || results_due.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #3000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
